### sv/opwc_pkg.sv
// Package for the on-off-keyed pulse width capture block.
// Holds the result beat type, end cause codes, register indexes and fixed widths.
// No dependencies; used by opwc_out_skid and ook_pulse_width_capture_core.
package opwc_pkg;

    localparam int unsigned WINDOW_W   = 24;
    localparam int unsigned IDLE_W     = 16;
    localparam int unsigned PMAX_W     = 16;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned SINCE_W    = 17;
    localparam int unsigned INDEX_W    = 7;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PMAX   = 2'd2;

    localparam logic [WINDOW_W-1:0] WINDOW_RST = 24'd5000000;
    localparam logic [IDLE_W-1:0]   IDLE_RST   = 16'd15000;
    localparam logic [PMAX_W-1:0]   PMAX_RST   = 16'd60000;

    typedef enum logic [1:0] {
        CAUSE_DEADLINE = 2'd0,
        CAUSE_IDLE     = 2'd1,
        CAUSE_FULL     = 2'd2,
        CAUSE_ABORT    = 2'd3
    } t_end_cause;

    typedef struct packed {
        logic               pulse_valid;
        logic [PMAX_W-1:0]  pulse_width;
        logic [INDEX_W-1:0] pulse_index;
        logic               capture_done;
        t_end_cause         end_cause;
        logic [COUNT_W-1:0] pulse_count;
    } t_result;

    typedef struct packed {
        logic out_vld;
        logic skid_vld;
    } t_skid_stat;

endpackage

### sv/opwc_out_skid.sv
// Output register with one skid entry for the pulse capture result stream.
// Depends on opwc_pkg for the result beat type and the status struct.
module opwc_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  opwc_pkg::t_result   i_data,
    input  logic                i_ready,
    output opwc_pkg::t_result   o_data,
    output opwc_pkg::t_skid_stat o_stat
);

    logic              r_out_vld;
    logic              r_skid_vld;
    opwc_pkg::t_result r_out;
    opwc_pkg::t_result r_skid;
    logic              w_take;

    assign w_take = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld  <= r_skid_vld || i_push;
            r_skid_vld <= 1'b0;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_data         = r_out;
    assign o_stat.out_vld  = r_out_vld;
    assign o_stat.skid_vld = r_skid_vld;

endmodule

### sv/ook_pulse_width_capture_core.sv
// Pulse width capture for one on-off-keyed burst; one input beat per line tick.
// A result beat is worked out from the registered input beat and presented from the output register.
// Throughput: one input beat per cycle, held back only while the skid entry is full.
// Reset: synchronous, active low; clears capture state and restores register defaults.
// Depends on opwc_pkg and opwc_out_skid.
module ook_pulse_width_capture_core #(
    parameter int unsigned MAX_PULSES = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [opwc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [opwc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Bits from 0: arm, line_level, abort, zero fill.
    input  logic [opwc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Bits from 0: pulse_width, pulse_index, end_cause, pulse_count, zero fill.
    output logic [opwc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Bit 0: pulse_valid.
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int unsigned TAKEN_W = $clog2(MAX_PULSES + 1);

    logic [opwc_pkg::WINDOW_W-1:0] r_window;
    logic [opwc_pkg::IDLE_W-1:0]   r_idle;
    logic [opwc_pkg::PMAX_W-1:0]   r_pmax;

    logic r_in_vld, r_in_arm, r_in_lvl, r_in_abort;

    logic                         r_active, n_active;
    logic                         r_capturing, n_capturing;
    logic                         r_prev, n_prev;
    logic [opwc_pkg::SINCE_W-1:0]  r_since, n_since;
    logic [opwc_pkg::WINDOW_W-1:0] r_elapsed, n_elapsed;
    logic [TAKEN_W-1:0]           r_taken, n_taken;

    logic                          w_fire;
    logic                          w_push;
    opwc_pkg::t_result             w_res;
    opwc_pkg::t_result             w_out;
    opwc_pkg::t_skid_stat          w_stat;
    logic [opwc_pkg::WINDOW_W-1:0] w_elapsed;
    logic [opwc_pkg::SINCE_W-1:0]  w_since;
    logic [TAKEN_W-1:0]            w_taken_inc;
    logic [TAKEN_W+7:0]            w_cnt_old;
    logic [TAKEN_W+7:0]            w_cnt_new;
    logic                          w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= opwc_pkg::WINDOW_RST;
            r_idle   <= opwc_pkg::IDLE_RST;
            r_pmax   <= opwc_pkg::PMAX_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                opwc_pkg::CFG_WINDOW: r_window <= i_cfg_wdata;
                opwc_pkg::CFG_IDLE:   r_idle   <= i_cfg_wdata[opwc_pkg::IDLE_W-1:0];
                opwc_pkg::CFG_PMAX:   r_pmax   <= i_cfg_wdata[opwc_pkg::PMAX_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_fire        = r_in_vld && !w_stat.skid_vld;
    assign s_axis_tready = !r_in_vld || !w_stat.skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_arm   <= s_axis_tdata[0];
            r_in_lvl   <= s_axis_tdata[1];
            r_in_abort <= s_axis_tdata[2];
        end
    end

    assign w_elapsed   = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
    assign w_since     = (&r_since) ? r_since : r_since + 1'b1;
    assign w_taken_inc = r_taken + 1'b1;
    assign w_full      = w_taken_inc >= TAKEN_W'(MAX_PULSES);
    assign w_cnt_old   = {8'd0, r_taken};
    assign w_cnt_new   = {8'd0, w_taken_inc};

    always_comb begin
        n_active    = r_active;
        n_capturing = r_capturing;
        n_prev      = r_prev;
        n_since     = r_since;
        n_elapsed   = r_elapsed;
        n_taken     = r_taken;
        w_push      = 1'b0;
        w_res.pulse_valid  = 1'b0;
        w_res.pulse_width  = '0;
        w_res.pulse_index  = '0;
        w_res.capture_done = 1'b1;
        w_res.end_cause    = opwc_pkg::CAUSE_DEADLINE;
        w_res.pulse_count  = w_cnt_old[opwc_pkg::COUNT_W-1:0];
        if (r_in_arm) begin
            n_active    = 1'b1;
            n_capturing = 1'b0;
            n_prev      = r_in_lvl;
            n_since     = '0;
            n_elapsed   = '0;
            n_taken     = '0;
        end else if (r_active) begin
            n_elapsed = w_elapsed;
            if (w_elapsed >= r_window) begin
                n_active    = 1'b0;
                n_capturing = 1'b0;
                w_push      = 1'b1;
            end else if (r_in_abort) begin
                n_active        = 1'b0;
                n_capturing     = 1'b0;
                w_push          = 1'b1;
                w_res.end_cause = opwc_pkg::CAUSE_ABORT;
            end else if (r_in_lvl != r_prev) begin
                n_prev  = r_in_lvl;
                n_since = '0;
                if (!r_capturing) begin
                    n_capturing = r_in_lvl;
                    n_taken     = '0;
                end else begin
                    n_taken = w_taken_inc;
                    w_push  = 1'b1;
                    w_res.pulse_valid  = 1'b1;
                    w_res.pulse_width  = (w_since > {1'b0, r_pmax}) ? r_pmax
                                         : w_since[opwc_pkg::PMAX_W-1:0];
                    w_res.pulse_index  = w_cnt_old[opwc_pkg::INDEX_W-1:0];
                    w_res.pulse_count  = w_cnt_new[opwc_pkg::COUNT_W-1:0];
                    w_res.capture_done = w_full;
                    w_res.end_cause    = w_full ? opwc_pkg::CAUSE_FULL
                                                : opwc_pkg::CAUSE_DEADLINE;
                    if (w_full) begin
                        n_active    = 1'b0;
                        n_capturing = 1'b0;
                    end
                end
            end else begin
                n_since = w_since;
                if (r_capturing && (w_since > {1'b0, r_idle})) begin
                    n_active        = 1'b0;
                    n_capturing     = 1'b0;
                    w_push          = 1'b1;
                    w_res.end_cause = opwc_pkg::CAUSE_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_capturing <= 1'b0;
            r_prev      <= 1'b0;
            r_since     <= '0;
            r_elapsed   <= '0;
            r_taken     <= '0;
        end else if (w_fire) begin
            r_active    <= n_active;
            r_capturing <= n_capturing;
            r_prev      <= n_prev;
            r_since     <= n_since;
            r_elapsed   <= n_elapsed;
            r_taken     <= n_taken;
        end
    end

    opwc_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire && w_push),
        .i_data  (w_res),
        .i_ready (m_axis_tready),
        .o_data  (w_out),
        .o_stat  (w_stat)
    );

    assign m_axis_tvalid = w_stat.out_vld;
    assign m_axis_tuser  = w_out.pulse_valid;
    assign m_axis_tlast  = w_out.capture_done;
    assign m_axis_tdata  = {7'd0, w_out.pulse_count, w_out.end_cause,
                            w_out.pulse_index, w_out.pulse_width};

`ifndef SYNTHESIS
    a_capture_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_capturing |-> r_active)
        else $error("capturing set while the capture is not active");

    a_taken_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= TAKEN_W'(MAX_PULSES))
        else $error("pulse count exceeds the store size");

    a_full_carries_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && (w_out.end_cause == opwc_pkg::CAUSE_FULL))
        |-> m_axis_tuser)
        else $error("store-full end beat without a measured pulse");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.skid_vld |-> w_stat.out_vld)
        else $error("skid entry holds a beat while the output register is empty");
`endif

endmodule
